FILE: hdl/assert_macros.svh
// Assertion macros shared by the checker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// Condition in one cycle that implies another in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/bbc_pkg.sv
// Shared types and constants of the bracket balance checker.
package bbc_pkg;

    localparam int STACK_DEPTH_DEF = 128;
    localparam int QUEUE_DEPTH     = 4;

    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    localparam logic signed [16:0] BAL_MAX = 17'sd65535;
    localparam logic signed [16:0] BAL_MIN = -17'sd65536;

    typedef enum logic [1:0] {
        BR_PAREN = 2'd0,
        BR_BRACE = 2'd1,
        BR_BRACK = 2'd2
    } t_bracket;

    typedef enum logic [1:0] {
        SB_NONE  = 2'd0,
        SB_ONE   = 2'd1,
        SB_MULTI = 2'd2
    } t_sbrace;

    typedef enum logic {
        KIND_LINE  = 1'b0,
        KIND_FINAL = 1'b1
    } t_kind;

    // Stack command broadcast along the cell chain.
    typedef struct packed {
        logic     push;
        logic     pop;
        t_bracket code;
    } t_stack_op;

    typedef struct packed {
        t_kind       kind;
        logic        balanced;
        logic [15:0] line_number;
    } t_result;

endpackage

FILE: hdl/bbc_cell.sv
// One stack cell: shifts down on push, up on pop.
module bbc_cell (
    input  logic                i_clk,
    input  bbc_pkg::t_stack_op  i_op,
    input  bbc_pkg::t_bracket   i_push_val,  // from the cell above (or new code)
    input  bbc_pkg::t_bracket   i_pop_val,   // from the cell below
    output bbc_pkg::t_bracket   o_val
);

    bbc_pkg::t_bracket r_val;

    always_ff @(posedge i_clk) begin
        if (i_op.push) begin
            r_val <= i_push_val;
        end else if (i_op.pop) begin
            r_val <= i_pop_val;
        end
    end

    assign o_val = r_val;

endmodule

FILE: hdl/bbc_parser.sv
// Lexer state, line bookkeeping and stack control of the checker.
`include "assert_macros.svh"

module bbc_parser #(
    parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [7:0]         i_char,
    input  logic               i_eoi,
    input  bbc_pkg::t_bracket  i_top,
    output bbc_pkg::t_stack_op o_op,
    output logic               o_res0_valid,
    output bbc_pkg::t_result   o_res0,
    output logic               o_res1_valid,
    output bbc_pkg::t_result   o_res1
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

    logic [CW-1:0]     r_count, n_count, b_count;
    logic              r_in_comment, n_in_comment;
    logic              r_in_string, n_in_string;
    logic              r_slash, n_slash;
    logic              r_star, n_star;
    logic              r_failed, n_failed, b_failed;
    logic              r_began, n_began, b_began;
    bbc_pkg::t_sbrace  r_sbs, n_sbs, b_sbs;
    logic              r_sbo, n_sbo, b_sbo;
    logic signed [16:0] r_brace, n_brace;
    logic              r_all_ok, n_all_ok;
    logic [15:0]       r_line, n_line;
    logic              r_has, n_has;

    logic              do_end, do_take, do_final;
    logic              line_emit, line_ok;
    logic [15:0]       line_num;
    logic              is_open, is_close;
    bbc_pkg::t_bracket code;

    // Bracket decode.
    always_comb begin
        is_open  = 1'b0;
        is_close = 1'b0;
        code     = bbc_pkg::BR_PAREN;
        unique case (i_char)
            bbc_pkg::CH_LPAREN: begin is_open  = 1'b1; code = bbc_pkg::BR_PAREN; end
            bbc_pkg::CH_LBRACE: begin is_open  = 1'b1; code = bbc_pkg::BR_BRACE; end
            bbc_pkg::CH_LBRACK: begin is_open  = 1'b1; code = bbc_pkg::BR_BRACK; end
            bbc_pkg::CH_RPAREN: begin is_close = 1'b1; code = bbc_pkg::BR_PAREN; end
            bbc_pkg::CH_RBRACE: begin is_close = 1'b1; code = bbc_pkg::BR_BRACE; end
            bbc_pkg::CH_RBRACK: begin is_close = 1'b1; code = bbc_pkg::BR_BRACK; end
            default: ;
        endcase
    end

    assign do_end   = i_accept && (i_eoi ? r_has : (i_char == bbc_pkg::CH_NL));
    assign do_take  = i_accept && !i_eoi && (i_char != bbc_pkg::CH_NL);
    assign do_final = i_accept && i_eoi;

    // Values as seen once the line has started.
    always_comb begin
        b_began  = r_has ? r_began : r_in_comment;
        b_sbs    = r_has ? r_sbs : bbc_pkg::SB_NONE;
        b_sbo    = r_has ? r_sbo : 1'b0;
        b_count  = (!r_has && !r_in_comment) ? '0 : r_count;
        b_failed = (!r_has && !r_in_comment) ? 1'b0 : r_failed;
    end

    always_comb begin
        n_count      = r_count;
        n_in_comment = r_in_comment;
        n_in_string  = r_in_string;
        n_slash      = r_slash;
        n_star       = r_star;
        n_failed     = r_failed;
        n_began      = r_began;
        n_sbs        = r_sbs;
        n_sbo        = r_sbo;
        n_brace      = r_brace;
        n_all_ok     = r_all_ok;
        n_line       = r_line;
        n_has        = r_has;
        line_emit    = 1'b0;
        line_ok      = 1'b0;
        line_num     = r_line;
        o_op         = '0;
        o_op.code    = code;

        if (do_end) begin
            n_began  = b_began;
            n_sbs    = b_sbs;
            n_sbo    = b_sbo;
            n_count  = b_count;
            n_failed = b_failed;
            n_slash  = 1'b0;
            n_star   = 1'b0;
            if (!r_in_comment) begin
                n_in_string = 1'b0;
                if (b_sbs == bbc_pkg::SB_ONE && !b_began) begin
                    if (b_sbo) begin
                        if (r_brace != bbc_pkg::BAL_MAX) n_brace = r_brace + 17'sd1;
                    end else begin
                        if (r_brace != bbc_pkg::BAL_MIN) n_brace = r_brace - 17'sd1;
                    end
                end else begin
                    line_emit = 1'b1;
                    line_ok   = !b_failed && (b_count == '0);
                    if (!line_ok) n_all_ok = 1'b0;
                end
            end
            if (r_line != 16'hFFFF) n_line = r_line + 16'd1;
            n_has = 1'b0;
        end

        if (do_take) begin
            n_has    = 1'b1;
            n_began  = b_began;
            n_count  = b_count;
            n_failed = b_failed;
            n_sbo    = b_sbo;
            n_sbs    = b_sbs;
            // single-brace test sees every byte of the line
            if (i_char == bbc_pkg::CH_LBRACE || i_char == bbc_pkg::CH_RBRACE) begin
                if (b_sbs == bbc_pkg::SB_NONE) begin
                    n_sbs = bbc_pkg::SB_ONE;
                    n_sbo = (i_char == bbc_pkg::CH_LBRACE);
                end else begin
                    n_sbs = bbc_pkg::SB_MULTI;
                end
            end else if (i_char != bbc_pkg::CH_SPACE && i_char != bbc_pkg::CH_TAB) begin
                n_sbs = bbc_pkg::SB_MULTI;
            end

            if (!b_failed) begin
                if (r_in_comment) begin
                    if (r_star && i_char == bbc_pkg::CH_SLASH) begin
                        n_in_comment = 1'b0;
                        n_star       = 1'b0;
                    end else begin
                        n_star = (i_char == bbc_pkg::CH_STAR);
                    end
                end else if (r_in_string) begin
                    if (i_char == bbc_pkg::CH_QUOTE) n_in_string = 1'b0;
                end else if (r_slash && i_char == bbc_pkg::CH_STAR) begin
                    n_in_comment = 1'b1;
                    n_star       = 1'b0;
                    n_slash      = 1'b0;
                end else begin
                    n_slash = (i_char == bbc_pkg::CH_SLASH);
                    if (i_char == bbc_pkg::CH_QUOTE) begin
                        n_in_string = 1'b1;
                    end else if (is_open) begin
                        if (b_count < FULL) begin
                            o_op.push = 1'b1;
                            n_count   = b_count + CW'(1);
                        end else begin
                            n_failed = 1'b1;
                        end
                    end else if (is_close) begin
                        if (b_count == '0 || i_top != code) begin
                            n_failed = 1'b1;
                        end else begin
                            o_op.pop = 1'b1;
                            n_count  = b_count - CW'(1);
                        end
                    end
                end
            end
        end
    end

    // Line verdict goes first; the final verdict follows it.
    always_comb begin
        o_res0_valid = line_emit || do_final;
        o_res1_valid = line_emit && do_final;
        o_res1.kind        = bbc_pkg::KIND_FINAL;
        o_res1.balanced    = n_all_ok && (n_brace == 17'sd0);
        o_res1.line_number = n_line;
        if (line_emit) begin
            o_res0.kind        = bbc_pkg::KIND_LINE;
            o_res0.balanced    = line_ok;
            o_res0.line_number = line_num;
        end else begin
            o_res0 = o_res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_in_comment <= 1'b0;
            r_in_string  <= 1'b0;
            r_slash      <= 1'b0;
            r_star       <= 1'b0;
            r_failed     <= 1'b0;
            r_began      <= 1'b0;
            r_sbs        <= bbc_pkg::SB_NONE;
            r_sbo        <= 1'b0;
            r_brace      <= '0;
            r_all_ok     <= 1'b1;
            r_line       <= 16'd1;
            r_has        <= 1'b0;
        end else begin
            r_count      <= n_count;
            r_in_comment <= n_in_comment;
            r_in_string  <= n_in_string;
            r_slash      <= n_slash;
            r_star       <= n_star;
            r_failed     <= n_failed;
            r_began      <= n_began;
            r_sbs        <= n_sbs;
            r_sbo        <= n_sbo;
            r_brace      <= n_brace;
            r_all_ok     <= n_all_ok;
            r_line       <= n_line;
            r_has        <= n_has;
        end
    end

    `ASSERT_ALWAYS(a_count_bound, r_count <= FULL, "stack count beyond depth")
    `ASSERT_ALWAYS(a_no_push_full, !o_op.push || (b_count < FULL), "push on full stack")
    `ASSERT_ALWAYS(a_no_pop_empty, !o_op.pop || (b_count != '0), "pop on empty stack")
    `ASSERT_NEXT(a_push_grows, o_op.push, r_count == $past(b_count) + CW'(1), "count did not follow push")

endmodule

FILE: hdl/bbc_out_queue.sv
// Small result queue: up to two writes and one read per cycle.
`include "assert_macros.svh"

module bbc_out_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr0,
    input  bbc_pkg::t_result i_wr0_data,
    input  logic             i_wr1,
    input  bbc_pkg::t_result i_wr1_data,
    output logic             o_room2,    // space for two more entries
    output logic             o_valid,
    output bbc_pkg::t_result o_data,
    input  logic             i_ready
);

    localparam int QD  = bbc_pkg::QUEUE_DEPTH;
    localparam int PW  = $clog2(QD);
    localparam int CNW = $clog2(QD + 1);

    bbc_pkg::t_result r_mem [QD];
    logic [PW-1:0]    r_wp, r_rp;
    logic [CNW-1:0]   r_cnt, n_cnt;
    logic             rd;

    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign rd      = o_valid && i_ready;
    assign o_room2 = (r_cnt <= CNW'(QD - 2));

    always_comb begin
        n_cnt = r_cnt + CNW'(i_wr0) + CNW'(i_wr1) - CNW'(rd);
    end

    always_ff @(posedge i_clk) begin
        if (i_wr0) r_mem[r_wp] <= i_wr0_data;
        if (i_wr1) r_mem[r_wp + PW'(1)] <= i_wr1_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + PW'(i_wr0) + PW'(i_wr1);
            r_rp  <= r_rp + PW'(rd);
            r_cnt <= n_cnt;
        end
    end

    `ASSERT_ALWAYS(a_q_bound, r_cnt <= CNW'(QD), "result queue overflow")
    `ASSERT_ALWAYS(a_q_order, !i_wr1 || i_wr0, "second slot written without first")

endmodule

FILE: hdl/bracket_balance_checker_unit.sv
// Top level of the bracket balance checker: parser, stack cell chain, result queue.
// Throughput: one byte per cycle while not stalled; stack cells push or pop together.
// A result enters the queue the cycle after its input; m_axis drains one per cycle when ready.
// End of input after a partial line can yield a line and a final result; input stalls
// only while the four-entry result queue lacks room for two results.
// Reset: i_rst_n synchronous active low clears control state; stack cells are not cleared.
module bracket_balance_checker_unit #(
    parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
    input  logic        s_axis_tuser,   // [0] end_of_input
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [0] balanced, [16:1] line_number, [23:17] zero
    output logic        m_axis_tuser    // [0] kind (0 line, 1 whole input)
);

    logic               accept;
    bbc_pkg::t_stack_op op;
    bbc_pkg::t_bracket  cell_val [STACK_DEPTH];
    logic               res0_valid, res1_valid;
    bbc_pkg::t_result   res0, res1, q_data;
    logic               room2;

    assign s_axis_tready = room2;
    assign accept        = s_axis_tvalid && s_axis_tready;

    bbc_parser #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_char       (s_axis_tdata),
        .i_eoi        (s_axis_tuser),
        .i_top        (cell_val[0]),
        .o_op         (op),
        .o_res0_valid (res0_valid),
        .o_res0       (res0),
        .o_res1_valid (res1_valid),
        .o_res1       (res1)
    );

    // Stack as a row of cells: cell 0 is the top; push shifts down, pop shifts up.
    for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
        bbc_pkg::t_bracket push_in, pop_in;
        if (g == 0) begin : g_top
            assign push_in = op.code;
        end else begin : g_mid
            assign push_in = cell_val[g-1];
        end
        if (g == STACK_DEPTH - 1) begin : g_bot
            assign pop_in = bbc_pkg::BR_PAREN;  // entry below the bottom is never read
        end else begin : g_up
            assign pop_in = cell_val[g+1];
        end
        bbc_cell u_cell (
            .i_clk      (i_clk),
            .i_op       (op),
            .i_push_val (push_in),
            .i_pop_val  (pop_in),
            .o_val      (cell_val[g])
        );
    end

    bbc_out_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr0      (res0_valid),
        .i_wr0_data (res0),
        .i_wr1      (res1_valid),
        .i_wr1_data (res1),
        .o_room2    (room2),
        .o_valid    (m_axis_tvalid),
        .o_data     (q_data),
        .i_ready    (m_axis_tready)
    );

    assign m_axis_tdata = {7'd0, q_data.line_number, q_data.balanced};
    assign m_axis_tuser = q_data.kind;

endmodule
